/* hw/rtl/slp_pkg.sv */
`default_nettype none

package slp_pkg;

	// line buffer size in bytes, the held line is cut one byte short of it
	localparam int LINE_CAPACITY = 64;

	localparam int DATA_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int QUOT_W  = 26;  // heap_total / 100 fits in 26 bits
	localparam int REM_W   = 7;   // heap_total % 100
	localparam int PCT_W   = 7;   // accepted percent values 0..100
	localparam int PROD2_W = 14;  // remainder times percent, at most 9900

	// ascii codes
	localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PCT  = 8'h25;
	localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9    = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UA   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UZ   = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LG   = 8'h67;
	localparam logic [BYTE_W-1:0] CH_LK   = 8'h6B;
	localparam logic [BYTE_W-1:0] CH_LM   = 8'h6D;
	localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

	localparam logic [DATA_W-1:0] PCT_MAX = 32'd100;

	// x / 100 == (x * RECIP_100) >> 37 for every 32-bit x
	localparam logic [31:0] RECIP_100 = 32'h51EB851F;
	localparam int RECIP_SH = 37;
	// y / 100 == (y * RECIP_SMALL) >> 19 for y below 43699
	localparam logic [12:0] RECIP_SMALL = 13'd5243;
	localparam int RECIP_SMALL_SH = 19;

	typedef enum logic [1:0] {
		PH_LEAD    = 2'd0,
		PH_DIGITS  = 2'd1,
		PH_TAIL    = 2'd2,
		PH_NODIGIT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		UNIT_NONE = 2'd0,
		UNIT_K    = 2'd1,
		UNIT_M    = 2'd2,
		UNIT_G    = 2'd3
	} unit_t;

	// snapshot of a finished line
	typedef struct packed {
		logic              valid;
		phase_t            phase;
		logic              pct;
		logic [DATA_W-1:0] value;
		logic              ovf;
		logic              gram_ok;
		unit_t             unit;
	} fin_t;

	// derived heap constants
	typedef struct packed {
		logic [QUOT_W-1:0] quot;
		logic [REM_W-1:0]  rem;
	} heap_t;

	// one result word
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] limit;
		status_t           status;
	} res_t;

	function automatic logic is_space(input logic [BYTE_W-1:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/slp_ifs.sv */
`default_nettype none

// text byte channel
interface slp_in_if;
	logic                      valid;
	logic                      ready;
	logic [slp_pkg::BYTE_W-1:0] byte_value;

	modport source (output valid, output byte_value, input ready);
	modport sink (input valid, input byte_value, output ready);
endinterface

// parsed limit channel
interface slp_out_if;
	logic                      valid;
	logic                      ready;
	logic [slp_pkg::DATA_W-1:0] limit_bytes;
	logic [1:0]                status;

	modport source (output valid, output limit_bytes, output status, input ready);
	modport sink (input valid, input limit_bytes, input status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/slp_heap.sv */
`default_nettype none

module slp_heap (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [slp_pkg::DATA_W-1:0] cfg_wdata,
	output slp_pkg::heap_t                  heap
);

	logic [slp_pkg::DATA_W-1:0] heap_q;
	logic [slp_pkg::QUOT_W-1:0] quot_q;
	logic [slp_pkg::REM_W-1:0]  rem_q;
	logic [63:0]                recip_prod;
	logic [slp_pkg::DATA_W-1:0] quot_x100;

	// quotient by reciprocal multiply at write time
	assign recip_prod = 64'(cfg_wdata) * 64'(slp_pkg::RECIP_100);
	assign quot_x100  = 32'(quot_q) * 32'd100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= '0;
			quot_q <= '0;
			rem_q  <= '0;
		end else begin
			if (cfg_we) begin
				heap_q <= cfg_wdata;
				quot_q <= recip_prod[slp_pkg::RECIP_SH +: slp_pkg::QUOT_W];
			end
			// remainder is registered from heap_q and quot_q once they have taken a write
			rem_q <= slp_pkg::REM_W'(heap_q - quot_x100);
		end
	end

	assign heap = '{quot: quot_q, rem: rem_q};

endmodule

`default_nettype wire

/* hw/rtl/slp_parse.sv */
`default_nettype none

module slp_parse #(
	parameter int LINE_CAPACITY = slp_pkg::LINE_CAPACITY
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       advance,
	input  wire logic                       valid_s1,
	input  wire logic [slp_pkg::BYTE_W-1:0] byte_s1,
	output slp_pkg::fin_t                   fin
);

	localparam int HW = $clog2(LINE_CAPACITY);
	localparam logic [HW-1:0] CUT_AT = HW'(LINE_CAPACITY - 1);

	logic [HW-1:0]              held_q,  b_held,  n_held;
	slp_pkg::phase_t            phase_q, b_phase, n_phase;
	logic [slp_pkg::DATA_W-1:0] acc_q,   b_acc,   n_acc;
	logic                       ovf_q,   b_ovf,   n_ovf;
	logic                       gram_q,  b_gram,  n_gram;
	logic                       pct_q,   b_pct,   n_pct;
	slp_pkg::unit_t             unit_q,  b_unit,  n_unit;

	logic                       cut;
	logic [slp_pkg::BYTE_W-1:0] low;
	logic [35:0]                acc_t;
	logic [slp_pkg::DATA_W-1:0] dig_acc;
	logic                       dig_ovf;

	// line end and cut detection, snapshot of the line being closed
	always_comb begin
		cut = (byte_s1 == slp_pkg::CH_LF) || (held_q == CUT_AT);
		fin.valid   = valid_s1 && cut && (phase_q != slp_pkg::PH_LEAD);
		fin.phase   = phase_q;
		fin.pct     = pct_q;
		fin.value   = acc_q;
		fin.ovf     = ovf_q;
		fin.gram_ok = gram_q;
		fin.unit    = unit_q;
	end

	// line state the byte is applied to
	always_comb begin
		if (cut) begin
			b_held  = '0;
			b_phase = slp_pkg::PH_LEAD;
			b_acc   = '0;
			b_ovf   = 1'b0;
			b_gram  = 1'b1;
			b_pct   = 1'b0;
			b_unit  = slp_pkg::UNIT_NONE;
		end else begin
			b_held  = held_q;
			b_phase = phase_q;
			b_acc   = acc_q;
			b_ovf   = ovf_q;
			b_gram  = gram_q;
			b_pct   = pct_q;
			b_unit  = unit_q;
		end
	end

	// digit accumulate, times ten plus digit, saturating
	always_comb begin
		acc_t   = ({4'b0, b_acc} << 3) + ({4'b0, b_acc} << 1) + {32'b0, byte_s1[3:0]};
		dig_ovf = (acc_t[35:32] != 4'b0);
		dig_acc = dig_ovf ? '1 : acc_t[31:0];
	end

	// next line state
	always_comb begin
		n_held  = b_held;
		n_phase = b_phase;
		n_acc   = b_acc;
		n_ovf   = b_ovf;
		n_gram  = b_gram;
		n_pct   = b_pct;
		n_unit  = b_unit;
		low     = byte_s1;
		if ((byte_s1 >= slp_pkg::CH_UA) && (byte_s1 <= slp_pkg::CH_UZ)) begin
			low = byte_s1 | slp_pkg::CASE_BIT;
		end
		if (byte_s1 != slp_pkg::CH_LF) begin
			n_held = b_held + 1'b1;
			if (slp_pkg::is_space(byte_s1)) begin
				if (b_phase == slp_pkg::PH_DIGITS) begin
					n_phase = slp_pkg::PH_TAIL;
				end
			end else begin
				n_pct = (byte_s1 == slp_pkg::CH_PCT);
				unique case (b_phase)
					slp_pkg::PH_LEAD: begin
						if (slp_pkg::is_digit(byte_s1)) begin
							n_phase = slp_pkg::PH_DIGITS;
							n_acc   = dig_acc;
							n_ovf   = b_ovf | dig_ovf;
						end else begin
							n_phase = slp_pkg::PH_NODIGIT;
						end
					end
					slp_pkg::PH_DIGITS: begin
						if (slp_pkg::is_digit(byte_s1)) begin
							n_acc = dig_acc;
							n_ovf = b_ovf | dig_ovf;
						end else begin
							n_phase = slp_pkg::PH_TAIL;
							if (low == slp_pkg::CH_LK) begin
								n_unit = slp_pkg::UNIT_K;
							end else if (low == slp_pkg::CH_LM) begin
								n_unit = slp_pkg::UNIT_M;
							end else if (low == slp_pkg::CH_LG) begin
								n_unit = slp_pkg::UNIT_G;
							end else begin
								n_gram = 1'b0;
							end
						end
					end
					slp_pkg::PH_TAIL: begin
						n_gram = 1'b0;
					end
					default: begin
						n_phase = b_phase;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			phase_q <= slp_pkg::PH_LEAD;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			gram_q  <= 1'b1;
			pct_q   <= 1'b0;
			unit_q  <= slp_pkg::UNIT_NONE;
		end else if (advance && valid_s1) begin
			held_q  <= n_held;
			phase_q <= n_phase;
			acc_q   <= n_acc;
			ovf_q   <= n_ovf;
			gram_q  <= n_gram;
			pct_q   <= n_pct;
			unit_q  <= n_unit;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/slp_eval.sv */
`default_nettype none

module slp_eval (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire slp_pkg::fin_t  fin,
	input  wire slp_pkg::heap_t heap,
	output slp_pkg::res_t       res
);

	// stage 2: line snapshot
	logic                       v_s2;
	slp_pkg::fin_t              fin_s2;

	// stage 3: status and partial products
	logic                        v_s3;
	slp_pkg::status_t            status_s3;
	logic                        pct_s3;
	logic [slp_pkg::DATA_W-1:0]  value_s3;
	slp_pkg::unit_t              unit_s3;
	logic [slp_pkg::DATA_W-1:0]  p1_s3;
	logic [slp_pkg::PROD2_W-1:0] p2_s3;

	slp_pkg::status_t            status;
	logic                        plain_ovf;
	logic [slp_pkg::PCT_W-1:0]   pct_val;
	logic [slp_pkg::DATA_W-1:0]  p1_full;
	logic [slp_pkg::PROD2_W-1:0] p2_full;
	logic [26:0]                 q_prod;
	logic [slp_pkg::DATA_W-1:0]  pct_limit;
	logic [slp_pkg::DATA_W-1:0]  plain_limit;

	// status decision
	always_comb begin
		plain_ovf = fin_s2.ovf;
		case (fin_s2.unit)
			slp_pkg::UNIT_K: plain_ovf = fin_s2.ovf || (fin_s2.value[31:22] != '0);
			slp_pkg::UNIT_M: plain_ovf = fin_s2.ovf || (fin_s2.value[31:12] != '0);
			slp_pkg::UNIT_G: plain_ovf = fin_s2.ovf || (fin_s2.value[31:2] != '0);
			default:         plain_ovf = fin_s2.ovf;
		endcase
		if (fin_s2.phase == slp_pkg::PH_NODIGIT) begin
			status = slp_pkg::ST_BAD;
		end else if (fin_s2.pct) begin
			status = (fin_s2.ovf || (fin_s2.value > slp_pkg::PCT_MAX)) ?
				slp_pkg::ST_RANGE : slp_pkg::ST_OK;
		end else if (!fin_s2.gram_ok) begin
			status = slp_pkg::ST_BAD;
		end else begin
			status = plain_ovf ? slp_pkg::ST_RANGE : slp_pkg::ST_OK;
		end
	end

	// heap*v/100 split as quot*v + rem*v/100
	always_comb begin
		pct_val = fin_s2.value[slp_pkg::PCT_W-1:0];
		p1_full = slp_pkg::DATA_W'(heap.quot) * slp_pkg::DATA_W'(pct_val);
		p2_full = slp_pkg::PROD2_W'(heap.rem) * slp_pkg::PROD2_W'(pct_val);
	end

	// final limit
	always_comb begin
		q_prod    = 27'(p2_s3) * 27'(slp_pkg::RECIP_SMALL);
		pct_limit = p1_s3 + 32'(q_prod[26:slp_pkg::RECIP_SMALL_SH]);
		case (unit_s3)
			slp_pkg::UNIT_K: plain_limit = {value_s3[21:0], 10'b0};
			slp_pkg::UNIT_M: plain_limit = {value_s3[11:0], 20'b0};
			slp_pkg::UNIT_G: plain_limit = {value_s3[1:0], 30'b0};
			default:         plain_limit = value_s3;
		endcase
		res.valid  = v_s3;
		res.status = status_s3;
		if (status_s3 != slp_pkg::ST_OK) begin
			res.limit = '0;
		end else if (pct_s3) begin
			res.limit = pct_limit;
		end else begin
			res.limit = plain_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s2 <= fin.valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fin_s2    <= fin;
			status_s3 <= status;
			pct_s3    <= fin_s2.pct;
			value_s3  <= fin_s2.value;
			unit_s3   <= fin_s2.unit;
			p1_s3     <= p1_full;
			p2_s3     <= p2_full;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/size_limit_line_parser_top.sv */
`default_nettype none

// channel  | dir | payload                      | handshake
// ---------+-----+------------------------------+-------------
// in_ch    | in  | byte_value[7:0]              | valid/ready
// out_ch   | out | limit_bytes[31:0], status[1:0] | valid/ready
// cfg      | in  | cfg_wdata[31:0] (heap_total) | cfg_we
//
// one text byte per cycle unless out_ch holds a result; a line result goes
// through input reg, parse, multiply and sum after the byte that closes it
// the multiply by ten of the digit accumulator sets the parse stage path
// arst_n clears the line state to empty and heap_total to zero
// a result held on out_ch stalls the whole pipeline, in_ch.ready follows it

module size_limit_line_parser_top #(
	parameter int LINE_CAPACITY = slp_pkg::LINE_CAPACITY
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	slp_in_if.sink                          in_ch,
	slp_out_if.source                       out_ch,
	input  wire logic                       cfg_we,
	input  wire logic [slp_pkg::DATA_W-1:0] cfg_wdata
);

	logic                       advance;
	logic                       v_s1;
	logic [slp_pkg::BYTE_W-1:0] byte_s1;
	logic                       out_v_q;
	logic [slp_pkg::DATA_W-1:0] limit_q;
	slp_pkg::status_t           status_q;
	slp_pkg::fin_t              fin;
	slp_pkg::heap_t             heap;
	slp_pkg::res_t              res;

	// pipeline moves unless the output word is held
	assign advance     = !out_v_q || out_ch.ready;
	assign in_ch.ready = advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s1 <= in_ch.byte_value;
		end
	end

	slp_heap u_heap (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.heap      (heap)
	);

	slp_parse #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s1 (v_s1),
		.byte_s1  (byte_s1),
		.fin      (fin)
	);

	slp_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.fin     (fin),
		.heap    (heap),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			limit_q  <= res.limit;
			status_q <= res.status;
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.limit_bytes = limit_q;
	assign out_ch.status      = status_q;

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned SEG_BYTES = 70;
	localparam logic [slp_pkg::BYTE_W-1:0] CH_VT = 8'h0B;
	localparam logic [slp_pkg::BYTE_W-1:0] CH_FF = 8'h0C;

	// one parsed limit word as it leaves the block
	typedef struct packed {
		logic [slp_pkg::DATA_W-1:0] limit;
		slp_pkg::status_t           status;
	} limit_word_t;

	// directed line: bytes packed msb first, result typed in where obvious
	typedef struct packed {
		logic [3:0]                 len;
		logic [8*12-1:0]            text;
		logic                       typed;
		logic [slp_pkg::DATA_W-1:0] lim;
		slp_pkg::status_t           st;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [slp_pkg::DATA_W-1:0] cfg_wdata;

	slp_in_if in_if ();
	slp_out_if out_if ();

	size_limit_line_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if),
		.out_ch(out_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// line parser mirror
	logic [slp_pkg::DATA_W-1:0] heap_cfg;
	int unsigned                held_len;
	slp_pkg::phase_t            line_phase;
	logic [slp_pkg::DATA_W-1:0] digit_val;
	logic                       digit_ovf;
	logic                       plain_ok;
	logic                       ends_pct;
	slp_pkg::unit_t             line_unit;

	limit_word_t                expected_limits [$];
	logic [slp_pkg::BYTE_W-1:0] line_text [$];

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned hold_ticket = 0;

	script_row_t script_rows [10] = '{
		'{4'd2, "0\n",                  1'b1, 32'd0,          slp_pkg::ST_OK},
		'{4'd5, "100%\n",               1'b1, 32'hFFFFFFFF,   slp_pkg::ST_OK},
		'{4'd2, "\t\n",                 1'b0, 32'd0,          slp_pkg::ST_OK},
		'{4'd2, "%\n",                  1'b1, 32'd0,          slp_pkg::ST_BAD},
		'{4'd3, "4g\n",                 1'b1, 32'd0,          slp_pkg::ST_RANGE},
		'{4'd3, {8'h00, 8'hFF, slp_pkg::CH_LF}, 1'b1, 32'd0,  slp_pkg::ST_BAD},
		'{4'd5, "101%\n",               1'b1, 32'd0,          slp_pkg::ST_RANGE},
		'{4'd3, "2K\n",                 1'b1, 32'd2048,       slp_pkg::ST_OK},
		'{4'd4, "3 k\n",                1'b1, 32'd0,          slp_pkg::ST_BAD},
		'{4'd4, "50%\n",                1'b0, 32'd0,          slp_pkg::ST_OK}
	};

	function automatic logic ws_byte(input logic [slp_pkg::BYTE_W-1:0] c);
		return (c == slp_pkg::CH_SP) || ((c >= slp_pkg::CH_TAB) && (c <= slp_pkg::CH_CR));
	endfunction

	function automatic void clear_line();
		held_len = 0;
		line_phase = slp_pkg::PH_LEAD;
		digit_val = '0;
		digit_ovf = 1'b0;
		plain_ok = 1'b1;
		ends_pct = 1'b0;
		line_unit = slp_pkg::UNIT_NONE;
	endfunction

	// decimal accumulate, saturating at 32 bits
	function automatic void add_digit(input logic [slp_pkg::BYTE_W-1:0] c);
		logic [35:0] t;
		t = 36'(digit_val) * 36'd10 + 36'(c - slp_pkg::CH_0);
		if (t > 36'hFFFFFFFF) begin
			digit_ovf = 1'b1;
			digit_val = '1;
		end else begin
			digit_val = t[31:0];
		end
	endfunction

	// evaluate the held line, returns 1 if it gives a word
	function automatic logic finish_line(output limit_word_t w);
		logic [63:0] wide;
		w.limit = '0;
		w.status = slp_pkg::ST_OK;
		if (line_phase == slp_pkg::PH_LEAD)
			return 1'b0;
		if (line_phase == slp_pkg::PH_NODIGIT) begin
			w.status = slp_pkg::ST_BAD;
		end else if (ends_pct) begin
			if (digit_ovf || (digit_val > slp_pkg::PCT_MAX)) begin
				w.status = slp_pkg::ST_RANGE;
			end else begin
				wide = (64'(heap_cfg) * 64'(digit_val)) / 64'd100;
				w.limit = wide[31:0];
			end
		end else if (!plain_ok) begin
			w.status = slp_pkg::ST_BAD;
		end else begin
			wide = 64'(digit_val) << (10 * int'(line_unit));
			if (digit_ovf || (wide[63:32] != '0))
				w.status = slp_pkg::ST_RANGE;
			else
				w.limit = wide[31:0];
		end
		return 1'b1;
	endfunction

	function automatic void take_byte(input logic [slp_pkg::BYTE_W-1:0] c);
		logic [slp_pkg::BYTE_W-1:0] low;
		held_len++;
		if (ws_byte(c)) begin
			if (line_phase == slp_pkg::PH_DIGITS)
				line_phase = slp_pkg::PH_TAIL;
			return;
		end
		ends_pct = (c == slp_pkg::CH_PCT);
		low = ((c >= slp_pkg::CH_UA) && (c <= slp_pkg::CH_UZ)) ? (c | slp_pkg::CASE_BIT) : c;
		case (line_phase)
			slp_pkg::PH_LEAD: begin
				if ((c >= slp_pkg::CH_0) && (c <= slp_pkg::CH_9)) begin
					line_phase = slp_pkg::PH_DIGITS;
					add_digit(c);
				end else begin
					line_phase = slp_pkg::PH_NODIGIT;
				end
			end
			slp_pkg::PH_DIGITS: begin
				if ((c >= slp_pkg::CH_0) && (c <= slp_pkg::CH_9)) begin
					add_digit(c);
				end else begin
					line_phase = slp_pkg::PH_TAIL;
					if (low == slp_pkg::CH_LK)
						line_unit = slp_pkg::UNIT_K;
					else if (low == slp_pkg::CH_LM)
						line_unit = slp_pkg::UNIT_M;
					else if (low == slp_pkg::CH_LG)
						line_unit = slp_pkg::UNIT_G;
					else
						plain_ok = 1'b0;
				end
			end
			slp_pkg::PH_TAIL: plain_ok = 1'b0;
			default: ;
		endcase
	endfunction

	// one text byte in, returns 1 with the word a closed line gives
	function automatic logic parse_byte(input logic [slp_pkg::BYTE_W-1:0] c,
			output limit_word_t w);
		logic got;
		got = 1'b0;
		w = '0;
		if ((c == slp_pkg::CH_LF) || (held_len + 1 >= slp_pkg::LINE_CAPACITY)) begin
			got = finish_line(w);
			clear_line();
			if (c == slp_pkg::CH_LF)
				return got;
		end
		take_byte(c);
		return got;
	endfunction

	// offer one byte, predict on acceptance
	task automatic send_byte(input logic [slp_pkg::BYTE_W-1:0] b, input logic no_gaps,
			input logic use_typed, input limit_word_t typed_word);
		limit_word_t w;
		while (!no_gaps && ($urandom_range(0, 99) < src_idle_pct)) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.byte_value <= b;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		if (parse_byte(b, w))
			expected_limits.push_back(use_typed ? typed_word : w);
	endtask

	// heap size write once every word is out and the pipe has drained
	task automatic write_heap(input logic [slp_pkg::DATA_W-1:0] v);
		in_if.valid <= 1'b0;
		while (expected_limits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		heap_cfg = v;
	endtask

	function automatic void add_text(input string s);
		foreach (s[i])
			line_text.push_back(s[i]);
	endfunction

	function automatic logic [slp_pkg::BYTE_W-1:0] any_blank();
		case ($urandom_range(0, 4))
			0: return slp_pkg::CH_SP;
			1: return slp_pkg::CH_TAB;
			2: return CH_VT;
			3: return CH_FF;
			default: return slp_pkg::CH_CR;
		endcase
	endfunction

	function automatic void add_blanks(input int unsigned most);
		repeat ($urandom_range(0, most))
			line_text.push_back(any_blank());
	endfunction

	function automatic void add_digit_run(input int unsigned n);
		repeat (n)
			line_text.push_back(8'(slp_pkg::CH_0 + $urandom_range(0, 9)));
	endfunction

	// random line, mostly well formed
	function automatic void compose_line();
		int unsigned kind;
		string units;
		logic [slp_pkg::BYTE_W-1:0] b;
		units = "kKmMgG";
		line_text.delete();
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			// plain size with optional unit
			add_blanks(2);
			if ($urandom_range(0, 7) == 0)
				line_text.push_back(slp_pkg::CH_0);
			case ($urandom_range(0, 3))
				0: add_text($sformatf("%0d", $urandom_range(0, 9)));
				1: add_text($sformatf("%0d", $urandom()));
				2: add_text($sformatf("%0d", $urandom_range(0, 5000)));
				default: add_digit_run($urandom_range(10, 13));
			endcase
			if ($urandom_range(0, 1) == 0)
				line_text.push_back(units[$urandom_range(0, 5)]);
			add_blanks(2);
			line_text.push_back(slp_pkg::CH_LF);
		end else if (kind < 60) begin
			// percent of heap, sometimes with text before the sign
			add_blanks(1);
			if ($urandom_range(0, 7) == 0)
				add_digit_run($urandom_range(10, 13));
			else
				add_text($sformatf("%0d", $urandom_range(0, 120)));
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					line_text.push_back(8'($urandom_range(33, 126)));
			line_text.push_back(slp_pkg::CH_PCT);
			add_blanks(2);
			line_text.push_back(slp_pkg::CH_LF);
		end else if (kind < 68) begin
			add_blanks(3);
			line_text.push_back(slp_pkg::CH_LF);
		end else if (kind < 80) begin
			// misplaced unit or stray text
			case ($urandom_range(0, 5))
				0: begin add_digit_run(2); add_text("k x"); end
				1: begin add_digit_run(1); add_text(" k"); end
				2: begin add_digit_run(3); add_text("mm"); end
				3: begin add_text("x"); add_digit_run(2); end
				4: begin add_digit_run(2); add_text("% x"); end
				default: begin add_digit_run(1); add_text("5 6"); end
			endcase
			line_text.push_back(slp_pkg::CH_LF);
		end else if (kind < 88) begin
			// mostly long enough to be cut
			repeat ($urandom_range(62, 140)) begin
				case ($urandom_range(0, 3))
					0: b = 8'(slp_pkg::CH_0 + $urandom_range(0, 9));
					1: b = any_blank();
					2: b = 8'($urandom_range(33, 126));
					default: b = 8'($urandom_range(0, 255));
				endcase
				line_text.push_back((b == slp_pkg::CH_LF) ? slp_pkg::CH_SP : b);
			end
			if ($urandom_range(0, 1) == 0)
				line_text.push_back(slp_pkg::CH_LF);
		end else begin
			repeat ($urandom_range(1, 10))
				line_text.push_back(8'($urandom_range(0, 255)));
			line_text.push_back(slp_pkg::CH_LF);
		end
	endfunction

	// result side: check each word, then pick next ready
	always @(posedge clk) begin : sink_side
		limit_word_t want;
		int unsigned hold_left;
		int unsigned hold_done;
		int unsigned calm_left;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_limits.size() == 0) begin
				$display("%0t unexpected word: limit %h status %0d", $time,
					out_if.limit_bytes, out_if.status);
				mismatches++;
			end else begin
				want = expected_limits.pop_front();
				if (out_if.limit_bytes !== want.limit) begin
					$display("%0t limit_bytes: expected %h actual %h", $time,
						want.limit, out_if.limit_bytes);
					mismatches++;
				end
				if (out_if.status !== want.status) begin
					$display("%0t status: expected %0d actual %0d", $time,
						want.status, out_if.status);
					mismatches++;
				end
			end
		end
		if (hold_left != 0) begin
			hold_left--;
			out_if.ready <= 1'b0;
		end else if (hold_ticket != hold_done) begin
			hold_done = hold_ticket;
			hold_left = HOLD_CYCLES;
			out_if.ready <= 1'b0;
		end else if (calm_left != 0) begin
			calm_left--;
			out_if.ready <= 1'b1;
		end else begin
			if ($urandom_range(0, 63) == 0)
				calm_left = 24;
			out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL size_limit_line_parser_top");
			$finish;
		end
	end

	initial begin : stimulus
		logic [slp_pkg::DATA_W-1:0] seg_heap [6];
		int unsigned sent;
		int unsigned len;
		logic paused;
		logic no_gaps;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_if.valid = 1'b0;
		in_if.byte_value = '0;
		out_if.ready = 1'b0;
		heap_cfg = '0;
		clear_line();
		seg_heap = '{32'd0, $urandom(), 32'd100, $urandom(), 32'd1, 32'hFFFFFFFF};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed lines
		src_idle_pct = 37;
		sink_idle_pct = 46;
		write_heap(32'hFFFFFFFF);
		foreach (script_rows[r]) begin
			len = script_rows[r].len;
			for (int i = 0; i < len; i++)
				send_byte(script_rows[r].text[8*(len-1-i) +: 8], 1'b0, script_rows[r].typed,
					limit_word_t'{script_rows[r].lim, script_rows[r].st});
		end

		// random lines, two segments per idling mode
		for (int seg = 0; seg < 6; seg++) begin
			write_heap(seg_heap[seg]);
			case (seg / 2)
				0: begin src_idle_pct = 37; sink_idle_pct = 46; end
				1: begin src_idle_pct = 46; sink_idle_pct = 37; end
				default: begin src_idle_pct = 0; sink_idle_pct = 0; end
			endcase
			// long output stall while bytes keep coming
			if (seg == 1)
				hold_ticket <= hold_ticket + 1;
			sent = 0;
			paused = 1'b0;
			while (sent < SEG_BYTES) begin
				compose_line();
				no_gaps = ($urandom_range(0, 5) == 0);
				foreach (line_text[i])
					send_byte(line_text[i], no_gaps, 1'b0, '0);
				sent += line_text.size();
				// input pause until every word is out
				if ((seg == 3) && !paused && (sent >= SEG_BYTES / 2)) begin
					paused = 1'b1;
					in_if.valid <= 1'b0;
					do
						@(posedge clk);
					while (expected_limits.size() != 0);
				end
			end
		end

		in_if.valid <= 1'b0;
		while (expected_limits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS size_limit_line_parser_top");
		else
			$display("FAIL size_limit_line_parser_top");
		$finish;
	end

endmodule

`default_nettype wire
